// File: rtl/sas_pkg.sv
// ----------------------------------------------------------------------------
// sas_pkg
// Shared types and constants of the sprite animation sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
package sas_pkg;

   localparam logic [2:0] KIND_REGISTER = 3'd0;
   localparam logic [2:0] KIND_CREATE   = 3'd1;
   localparam logic [2:0] KIND_DESTROY  = 3'd2;
   localparam logic [2:0] KIND_TICK     = 3'd3;
   localparam logic [2:0] KIND_QUERY    = 3'd4;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_FULL   = 2'd1;
   localparam logic [1:0] STATUS_UNUSED = 2'd2;

   localparam logic [30:0] ACC_MAX = 31'h7FFF_FFFF;

   // One command as handed from the front to the back.
   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  index;
      logic [9:0]  texture_id;
      logic [7:0]  frame_count;
      logic [7:0]  columns;
      logic [23:0] time_us;
      logic [11:0] tile_width;
      logic [11:0] tile_height;
      logic [11:0] start_x;
      logic [11:0] start_y;
      logic        looped;
   } cmd_type;

   // pattern record: texture, frames, columns, period, loop, tw, th, sx, sy
   typedef struct packed {
      logic [9:0]  texture;
      logic [7:0]  frames;
      logic [7:0]  cols;
      logic [23:0] period;
      logic        looped;
      logic [11:0] tw;
      logic [11:0] th;
      logic [11:0] sx;
      logic [11:0] sy;
   } pattern_type;

   typedef struct packed {
      logic [7:0]  pattern;
      logic [7:0]  frame;
      logic [30:0] acc;
      logic        stopped;
   } player_type;

endpackage
`default_nettype wire

// File: rtl/sas_ram.sv
// ----------------------------------------------------------------------------
// sas_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module sas_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                       clock,
   input  wire logic                                       we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  wire logic [WIDTH-1:0]                           wdata,
   output      logic [WIDTH-1:0]                           rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end
endmodule
`default_nettype wire

// File: rtl/sas_front.sv
// ----------------------------------------------------------------------------
// sas_front
// Accepts commands and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module sas_front
   import sas_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output      logic    full,
   output      logic    q_valid,
   output      cmd_type q_cmd,
   input  wire logic    pop
);
   cmd_type    slot_ff [2];
   logic       wr_ff, rd_ff, wr_in, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full    = cnt_ff == 2'd2;
   assign q_valid = cnt_ff != 2'd0;
   assign q_cmd   = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff ^ push;
      rd_in  = rd_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end
endmodule
`default_nettype wire

// File: rtl/sas_back.sv
// ----------------------------------------------------------------------------
// sas_back
// Executes one command at a time against the pattern and player tables.
// ----------------------------------------------------------------------------
`default_nettype none
module sas_back
   import sas_pkg::*;
#(
   parameter int PATTERN_SLOTS = 128,
   parameter int PLAYER_SLOTS  = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        q_valid,
   input  wire cmd_type     q_cmd,
   output      logic        pop,
   output      logic        rsp_valid,
   output      logic [1:0]  rsp_status,
   output      logic [7:0]  rsp_slot,
   output      logic [9:0]  rsp_out_texture,
   output      logic [19:0] rsp_source_x,
   output      logic [19:0] rsp_source_y,
   output      logic [11:0] rsp_out_tile_width,
   output      logic [11:0] rsp_out_tile_height,
   output      logic [7:0]  rsp_current_frame,
   output      logic        rsp_stopped
);
   localparam int PAW = (PATTERN_SLOTS > 1) ? $clog2(PATTERN_SLOTS) : 1;
   localparam int PLW = (PLAYER_SLOTS > 1) ? $clog2(PLAYER_SLOTS) : 1;
   localparam int PW  = $bits(pattern_type);
   localparam int LW  = $bits(player_type);

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_PREAD, S_PWAIT, S_PUSE, S_TADV, S_QDIV, S_QMUL, S_QOUT
   } state_type;

   state_type state_ff;
   cmd_type   cmd_ff;
   logic [PATTERN_SLOTS-1:0] pat_used_ff;
   logic [PLAYER_SLOTS-1:0]  ply_used_ff;
   logic [8:0]  cnt_ff;
   logic [7:0]  rem_ff, quo_ff;
   logic [3:0]  div_ff;

   // pattern RAM
   logic            pat_we;
   logic [PAW-1:0]  pat_addr;
   pattern_type     pat_wdata, pat_rd;
   logic [PW-1:0]   pat_rbits;
   // player RAM
   logic            ply_we;
   logic [PLW-1:0]  ply_addr;
   player_type      ply_wdata, ply_rd, adv;
   logic [LW-1:0]   ply_rbits;
   logic [PLW-1:0]  ply_idx_ff;

   assign pat_rd = pattern_type'(pat_rbits);
   assign ply_rd = player_type'(ply_rbits);

   sas_ram #(.WIDTH(PW), .DEPTH(PATTERN_SLOTS)) u_pat (
      .clock, .we(pat_we), .addr(pat_addr), .wdata(pat_wdata), .rdata(pat_rbits));
   sas_ram #(.WIDTH(LW), .DEPTH(PLAYER_SLOTS)) u_ply (
      .clock, .we(ply_we), .addr(ply_addr), .wdata(ply_wdata), .rdata(ply_rbits));

   logic idx_pat_ok, idx_ply_ok;
   assign idx_pat_ok = ({1'b0, cmd_ff.index} < 9'(PATTERN_SLOTS)) &&
                       pat_used_ff[cmd_ff.index[PAW-1:0]];
   assign idx_ply_ok = ({1'b0, cmd_ff.index} < 9'(PLAYER_SLOTS)) &&
                       ply_used_ff[cmd_ff.index[PLW-1:0]];

   // tick advance of one player record (combinational from RAM read)
   logic [8:0]  nf;
   logic [31:0] sum;
   logic [30:0] acc_sub;
   always_comb begin
      adv     = ply_rd;
      acc_sub = ply_rd.acc;
      if (ply_rd.acc >= {7'd0, pat_rd.period}) begin
         nf = {1'b0, ply_rd.frame} + 9'd1;
         if (nf >= {1'b0, pat_rd.frames}) begin
            if (pat_rd.looped) begin
               nf = 9'd0;
            end else begin
               nf = (pat_rd.frames != 8'd0) ? {1'b0, pat_rd.frames} - 9'd1 : 9'd0;
               adv.stopped = 1'b1;
            end
         end
         adv.frame = nf[7:0];
         acc_sub   = ply_rd.acc - {7'd0, pat_rd.period};
      end else begin
         nf = 9'd0;
      end
      sum     = {1'b0, acc_sub} + {8'd0, cmd_ff.time_us};
      adv.acc = sum[31] ? ACC_MAX : sum[30:0];
   end

   // RAM port control
   always_comb begin
      pat_we    = 1'b0;
      pat_wdata = '{texture: cmd_ff.texture_id, frames: cmd_ff.frame_count,
                    cols: cmd_ff.columns, period: cmd_ff.time_us,
                    looped: cmd_ff.looped, tw: cmd_ff.tile_width,
                    th: cmd_ff.tile_height, sx: cmd_ff.start_x, sy: cmd_ff.start_y};
      pat_addr  = ply_rd.pattern[PAW-1:0];
      ply_we    = 1'b0;
      ply_wdata = adv;
      ply_addr  = ply_idx_ff;
      case (state_ff)
         S_SCAN: begin
            if (cmd_ff.kind == KIND_REGISTER) begin
               pat_addr = cnt_ff[PAW-1:0];
               pat_we   = (cnt_ff < 9'(PATTERN_SLOTS)) && !pat_used_ff[cnt_ff[PAW-1:0]];
            end else begin
               ply_addr  = cnt_ff[PLW-1:0];
               ply_we    = (cnt_ff < 9'(PLAYER_SLOTS)) && !ply_used_ff[cnt_ff[PLW-1:0]];
               ply_wdata = '{pattern: cmd_ff.index, frame: 8'd0, acc: 31'd0,
                             stopped: 1'b0};
            end
         end
         S_TADV:  ply_we = 1'b1;
         default: ;
      endcase
   end

   logic [23:0] prod;
   assign prod = {12'd0, pat_rd.tw} * {16'd0, rem_ff};

   always_ff @(posedge clock) begin
      logic rsp_valid_in, pop_in;
      rsp_valid_in = 1'b0;
      pop_in       = 1'b0;
      if (reset) begin
         state_ff    <= S_IDLE;
         pat_used_ff <= '0;
         ply_used_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (q_valid && !pop) begin
                  cmd_ff <= q_cmd;
                  pop_in = 1'b1;
                  cnt_ff <= 9'd0;
                  {rsp_status, rsp_slot, rsp_out_texture, rsp_source_x, rsp_source_y,
                   rsp_out_tile_width, rsp_out_tile_height, rsp_current_frame,
                   rsp_stopped} <= '0;
                  case (q_cmd.kind)
                     KIND_REGISTER: state_ff <= S_SCAN;
                     KIND_CREATE:   state_ff <= S_SCAN;
                     KIND_DESTROY:  state_ff <= S_PUSE;
                     KIND_TICK:     state_ff <= S_PREAD;
                     KIND_QUERY:    state_ff <= S_PUSE;
                     default: begin
                        rsp_valid_in = 1'b1;
                     end
                  endcase
               end
            end
            S_SCAN: begin
               if (cmd_ff.kind == KIND_CREATE && !idx_pat_ok) begin
                  rsp_status <= STATUS_UNUSED;
                  rsp_valid_in = 1'b1;
                  state_ff   <= S_IDLE;
               end else if (pat_we) begin
                  pat_used_ff[cnt_ff[PAW-1:0]] <= 1'b1;
                  rsp_slot  <= cnt_ff[7:0];
                  rsp_valid_in = 1'b1;
                  state_ff  <= S_IDLE;
               end else if (ply_we) begin
                  ply_used_ff[cnt_ff[PLW-1:0]] <= 1'b1;
                  rsp_slot  <= cnt_ff[7:0];
                  rsp_valid_in = 1'b1;
                  state_ff  <= S_IDLE;
               end else if ((cmd_ff.kind == KIND_REGISTER &&
                             cnt_ff >= 9'(PATTERN_SLOTS - 1)) ||
                            (cmd_ff.kind != KIND_REGISTER &&
                             cnt_ff >= 9'(PLAYER_SLOTS - 1))) begin
                  rsp_status <= STATUS_FULL;
                  rsp_valid_in = 1'b1;
                  state_ff   <= S_IDLE;
               end else begin
                  cnt_ff <= cnt_ff + 9'd1;
               end
            end
            S_PUSE: begin
               // destroy or query: check, then fetch player
               if (!idx_ply_ok) begin
                  rsp_status <= STATUS_UNUSED;
                  rsp_valid_in = 1'b1;
                  state_ff   <= S_IDLE;
               end else if (cmd_ff.kind == KIND_DESTROY) begin
                  ply_used_ff[cmd_ff.index[PLW-1:0]] <= 1'b0;
                  rsp_valid_in = 1'b1;
                  state_ff  <= S_IDLE;
               end else begin
                  ply_idx_ff <= cmd_ff.index[PLW-1:0];
                  cnt_ff     <= 9'd0;
                  state_ff   <= S_PREAD;
               end
            end
            S_PREAD: begin
               // tick: walk slots; query: single slot already set
               if (cmd_ff.kind == KIND_TICK) begin
                  if (cnt_ff >= 9'(PLAYER_SLOTS)) begin
                     rsp_valid_in = 1'b1;
                     state_ff  <= S_IDLE;
                  end else if (ply_used_ff[cnt_ff[PLW-1:0]]) begin
                     ply_idx_ff <= cnt_ff[PLW-1:0];
                     div_ff     <= 4'd0;
                     state_ff   <= S_PWAIT;
                  end else begin
                     cnt_ff <= cnt_ff + 9'd1;
                  end
               end else begin
                  div_ff   <= 4'd0;
                  state_ff <= S_PWAIT;
               end
            end
            S_PWAIT: begin
               // player read lands, then pattern read lands
               if (div_ff == 4'd2) begin
                  if ({1'b0, ply_rd.pattern} >= 9'(PATTERN_SLOTS)) begin
                     if (cmd_ff.kind == KIND_TICK) begin
                        cnt_ff   <= cnt_ff + 9'd1;
                        state_ff <= S_PREAD;
                     end else begin
                        rsp_status <= STATUS_UNUSED;
                        rsp_valid_in = 1'b1;
                        state_ff   <= S_IDLE;
                     end
                  end else if (cmd_ff.kind == KIND_TICK) begin
                     state_ff <= S_TADV;
                  end else begin
                     rem_ff   <= ply_rd.frame;
                     quo_ff   <= 8'd0;
                     div_ff   <= 4'd0;
                     state_ff <= S_QDIV;
                  end
               end else begin
                  div_ff <= div_ff + 4'd1;
               end
            end
            S_TADV: begin
               cnt_ff   <= cnt_ff + 9'd1;
               state_ff <= S_PREAD;
            end
            S_QDIV: begin
               // repeated subtract, at most 255 steps
               if (pat_rd.cols != 8'd0 && rem_ff >= pat_rd.cols) begin
                  rem_ff <= rem_ff - pat_rd.cols;
                  quo_ff <= quo_ff + 8'd1;
               end else begin
                  state_ff <= S_QMUL;
               end
            end
            S_QMUL: begin
               rsp_source_x <= {8'd0, pat_rd.sx} + prod[19:0];
               rem_ff       <= quo_ff;
               state_ff     <= S_QOUT;
            end
            S_QOUT: begin
               rsp_source_y        <= {8'd0, pat_rd.sy} +
                                      20'({12'd0, pat_rd.th} * {16'd0, quo_ff});
               rsp_out_texture     <= pat_rd.texture;
               rsp_out_tile_width  <= pat_rd.tw;
               rsp_out_tile_height <= pat_rd.th;
               rsp_current_frame   <= ply_rd.frame;
               rsp_stopped         <= ply_rd.stopped;
               rsp_valid_in = 1'b1;
               state_ff            <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
      rsp_valid <= rsp_valid_in;
      pop       <= pop_in;
   end
endmodule
`default_nettype wire

// File: rtl/sprite_animation_sequencer_top.sv
// ----------------------------------------------------------------------------
// sprite_animation_sequencer_top
// Sprite-sheet animation sequencer: pattern and player tables, tick, query.
// ----------------------------------------------------------------------------
// Usage:
//  - Command channel: drive req_* with start high; the transaction is taken at
//    an edge where busy is low. busy rises while the two-entry command queue
//    is full.
//  - Result channel: every command yields exactly one transaction, shown for
//    one cycle with rsp_valid high. The receiver cannot stall it.
//  - Work per command: an unknown kind is answered without touching the
//    tables; destroy clears the player's used flag; register/create do a
//    first free slot search, one slot a cycle; query splits the frame into
//    row/column by repeated subtraction of the column count, one cycle per
//    subtraction; tick walks all player slots and advances each used one.
//  - Throughput is set by the single back-end sequencer, one command at a
//    time; the queue lets the next commands be taken while it works.
//  - Reset (synchronous) clears the used flags of both tables and the queue;
//    table RAMs hold stale data that is never read before being written.
// ----------------------------------------------------------------------------
`default_nettype none
module sprite_animation_sequencer_top
   import sas_pkg::*;
#(
   parameter int PATTERN_SLOTS = 128,
   parameter int PLAYER_SLOTS  = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output      logic        busy,
   input  wire logic [2:0]  req_kind,
   input  wire logic [7:0]  req_index,
   input  wire logic [9:0]  req_texture_id,
   input  wire logic [7:0]  req_frame_count,
   input  wire logic [7:0]  req_columns,
   input  wire logic [23:0] req_time_us,
   input  wire logic [11:0] req_tile_width,
   input  wire logic [11:0] req_tile_height,
   input  wire logic [11:0] req_start_x,
   input  wire logic [11:0] req_start_y,
   input  wire logic        req_looped,
   output      logic        rsp_valid,
   output      logic [1:0]  rsp_status,
   output      logic [7:0]  rsp_slot,
   output      logic [9:0]  rsp_out_texture,
   output      logic [19:0] rsp_source_x,
   output      logic [19:0] rsp_source_y,
   output      logic [11:0] rsp_out_tile_width,
   output      logic [11:0] rsp_out_tile_height,
   output      logic [7:0]  rsp_current_frame,
   output      logic        rsp_stopped
);
   cmd_type req_cmd, q_cmd;
   logic    q_valid, pop, push;

   assign req_cmd = '{kind: req_kind, index: req_index, texture_id: req_texture_id,
                      frame_count: req_frame_count, columns: req_columns,
                      time_us: req_time_us, tile_width: req_tile_width,
                      tile_height: req_tile_height, start_x: req_start_x,
                      start_y: req_start_y, looped: req_looped};
   assign push = start && !busy;

   // front: command queue
   sas_front u_front (
      .clock, .reset, .push, .push_cmd(req_cmd), .full(busy),
      .q_valid, .q_cmd, .pop);

   // back: table sequencer
   sas_back #(.PATTERN_SLOTS(PATTERN_SLOTS), .PLAYER_SLOTS(PLAYER_SLOTS)) u_back (
      .clock, .reset, .q_valid, .q_cmd, .pop,
      .rsp_valid, .rsp_status, .rsp_slot, .rsp_out_texture, .rsp_source_x,
      .rsp_source_y, .rsp_out_tile_width, .rsp_out_tile_height,
      .rsp_current_frame, .rsp_stopped);
endmodule
`default_nettype wire

// File: rtl/sas_checker.sv
// ----------------------------------------------------------------------------
// sas_checker
// Port-level checks of the sprite animation sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
module sas_checker
   import sas_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       busy,
   input wire logic       rsp_valid,
   input wire logic [1:0] rsp_status,
   input wire logic [7:0] rsp_slot,
   input wire logic [7:0] rsp_current_frame
);
   a_no_result_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid) else $error("result right after reset");
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= STATUS_UNUSED) else $error("bad status");
   a_fail_no_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |-> rsp_slot == 8'd0)
      else $error("slot on failure");
   a_fail_no_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |-> rsp_current_frame == 8'd0)
      else $error("frame on failure");
   a_busy_reset: assert property (@(posedge clock)
      reset |=> !busy) else $error("busy after reset");
endmodule

bind sprite_animation_sequencer_top sas_checker u_sas_checker (
   .clock, .reset, .busy, .rsp_valid, .rsp_status, .rsp_slot,
   .rsp_current_frame);
`default_nettype wire
